### src/thermostat_cut_with_sensor_watchdog_defines.svh
// ---------------------------------------------------------------------------
// Thermostat cut with sensor watchdog: assertion macros
// Shared property macros for the checker, clocked on clk, reset rst.
// ---------------------------------------------------------------------------
`ifndef THERMOSTAT_CUT_WITH_SENSOR_WATCHDOG_DEFINES_SVH
`define THERMOSTAT_CUT_WITH_SENSOR_WATCHDOG_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define THCUT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("thcut same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define THCUT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("thcut next-cycle check failed");

// Checked in the cycle after reset is seen.
`define THCUT_ASSERT_RST(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("thcut reset check failed");

`endif

### src/thcut_pkg.sv
// ---------------------------------------------------------------------------
// Thermostat cut package
// Widths, codes and shared types for the thermostat cut with sensor watchdog.
// ---------------------------------------------------------------------------
package thcut_pkg;

  localparam int TEMP_W     = 12;
  localparam int TIME_W     = 32;
  localparam int NSENS      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int SENS_TANK   = 0;
  localparam int SENS_TRIAC  = 1;
  localparam int SENS_CUSTOM = 2;

  // -127 degrees, saturated to the most negative code on narrow widths.
  localparam int TEMP_MIN  = -(2 ** (TEMP_W - 1));
  localparam int FAULT_INT = (-2032 < TEMP_MIN) ? TEMP_MIN : -2032;
  localparam logic [TEMP_W-1:0] FAULT_VAL = TEMP_W'(FAULT_INT);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE         = 3'd0,
    REG_CONTROL_MODE   = 3'd1,
    REG_TURN_ON_LEVEL  = 3'd2,
    REG_TURN_OFF_LEVEL = 3'd3,
    REG_MAX_ERROR_MS   = 3'd4,
    REG_SENSOR_PRESENT = 3'd5,
    REG_MANUAL_MODE    = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_NONE      = 2'd0,
    CMD_START     = 2'd1,
    CMD_TEMP_CUT  = 2'd2,
    CMD_FAULT_CUT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_AUTO   = 2'd1,
    MODE_MANUAL = 2'd2,
    MODE_BOTH   = 2'd3
  } mode_t;

  typedef struct packed {
    logic                     enable;
    mode_t                    control_mode;
    logic signed [TEMP_W-1:0] turn_on_level;
    logic signed [TEMP_W-1:0] turn_off_level;
    logic [TIME_W-1:0]        max_error_ms;
    logic [NSENS-1:0]         sensor_present;
    logic                     manual_mode;
  } cfg_t;

  // One classified word as it sits in the queue.
  typedef struct packed {
    logic [TIME_W-1:0]             now_ms;
    logic [NSENS-1:0][TEMP_W-1:0]  reading;
    logic [NSENS-1:0]              good;
    logic                          manual_path;
    logic                          pwm_active;
    logic                          automatic_active;
  } item_t;

endpackage

### src/thcut_front.sv
// ---------------------------------------------------------------------------
// Thermostat cut front end
// Classifies an incoming word: which sensors gave a usable reading and
// whether the manual control path is active.
// ---------------------------------------------------------------------------
module thcut_front (
  input  thcut_pkg::cfg_t                    cfg,
  input  logic [thcut_pkg::TIME_W-1:0]       now_ms,
  input  logic signed [thcut_pkg::TEMP_W-1:0] tank_reading,
  input  logic                               tank_valid,
  input  logic signed [thcut_pkg::TEMP_W-1:0] triac_reading,
  input  logic                               triac_valid,
  input  logic signed [thcut_pkg::TEMP_W-1:0] custom_reading,
  input  logic                               custom_valid,
  input  logic                               manual_override,
  input  logic                               pwm_active,
  input  logic                               automatic_active,
  output thcut_pkg::item_t                   item
);

  logic [thcut_pkg::NSENS-1:0] valid_bits;

  always_comb begin
    valid_bits[thcut_pkg::SENS_TANK]   = tank_valid;
    valid_bits[thcut_pkg::SENS_TRIAC]  = triac_valid;
    valid_bits[thcut_pkg::SENS_CUSTOM] = custom_valid;

    item.now_ms                          = now_ms;
    item.reading[thcut_pkg::SENS_TANK]   = tank_reading;
    item.reading[thcut_pkg::SENS_TRIAC]  = triac_reading;
    item.reading[thcut_pkg::SENS_CUSTOM] = custom_reading;
    // A reading only counts for a sensor that is configured.
    item.good             = valid_bits & cfg.sensor_present;
    item.manual_path      = cfg.manual_mode | manual_override;
    item.pwm_active       = pwm_active;
    item.automatic_active = automatic_active;
  end

endmodule

### src/thcut_queue.sv
// ---------------------------------------------------------------------------
// Thermostat cut queue
// Two-entry queue of classified words between front end and back end.
// ---------------------------------------------------------------------------
module thcut_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  thcut_pkg::item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             nonempty,
  output thcut_pkg::item_t head
);

  thcut_pkg::item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### src/thcut_back.sv
// ---------------------------------------------------------------------------
// Thermostat cut back end
// Holds the sensor state, runs the watchdog and the load control, and
// drives the result register.
// ---------------------------------------------------------------------------
module thcut_back (
  input  logic                         clk,
  input  logic                         rst,
  input  thcut_pkg::cfg_t              cfg,
  input  logic                         q_nonempty,
  input  thcut_pkg::item_t             q_head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output thcut_pkg::cmd_t              command,
  output logic [thcut_pkg::TEMP_W-1:0] tank_temp,
  output logic [thcut_pkg::TEMP_W-1:0] triac_temp,
  output logic [thcut_pkg::TEMP_W-1:0] custom_temp,
  output logic [thcut_pkg::NSENS-1:0]  fault_flags
);

  logic [thcut_pkg::TEMP_W-1:0] value      [thcut_pkg::NSENS];
  logic [thcut_pkg::TEMP_W-1:0] value_next [thcut_pkg::NSENS];
  logic [thcut_pkg::TIME_W-1:0] last_ok      [thcut_pkg::NSENS];
  logic [thcut_pkg::TIME_W-1:0] last_ok_next [thcut_pkg::NSENS];
  logic [thcut_pkg::TIME_W-1:0] age          [thcut_pkg::NSENS];
  logic [thcut_pkg::NSENS-1:0]  fault;
  logic [thcut_pkg::NSENS-1:0]  fault_next;
  logic [thcut_pkg::NSENS-1:0]  timeout;
  logic                         below;
  logic                         above;
  logic                         start;
  logic                         cut;
  logic                         fault_cut;
  thcut_pkg::cmd_t              cmd_next;

  assign pop = q_nonempty && (!out_valid || out_ready);

  always_comb begin
    for (int i = 0; i < thcut_pkg::NSENS; i++) begin
      age[i] = q_head.now_ms - last_ok[i];
      // A fresh reading resets the age to zero, so only a stale one can time out.
      timeout[i] = !q_head.good[i] && (age[i] > cfg.max_error_ms);
      value_next[i]   = value[i];
      last_ok_next[i] = last_ok[i];
      fault_next[i]   = fault[i];
      if (cfg.enable) begin
        if (!cfg.sensor_present[i]) begin
          value_next[i] = thcut_pkg::FAULT_VAL;
          fault_next[i] = 1'b0;
        end else if (timeout[i]) begin
          value_next[i] = thcut_pkg::FAULT_VAL;
          fault_next[i] = 1'b1;
        end else if (q_head.good[i]) begin
          value_next[i]   = q_head.reading[i];
          last_ok_next[i] = q_head.now_ms;
          fault_next[i]   = 1'b0;
        end
      end
    end

    below = $signed(value_next[thcut_pkg::SENS_TANK]) < cfg.turn_on_level;
    above = $signed(value_next[thcut_pkg::SENS_TANK]) >= cfg.turn_off_level;

    start = 1'b0;
    cut   = 1'b0;
    if (!fault_next[thcut_pkg::SENS_TANK]) begin
      case (cfg.control_mode)
        thcut_pkg::MODE_AUTO: begin
          start = !cfg.manual_mode && below;
          cut   = !cfg.manual_mode && above &&
                  (q_head.pwm_active || q_head.automatic_active);
        end
        thcut_pkg::MODE_MANUAL: begin
          start = q_head.manual_path && below;
          cut   = q_head.manual_path && above && q_head.pwm_active;
        end
        thcut_pkg::MODE_BOTH: begin
          start = below;
          cut   = above && (q_head.pwm_active || q_head.automatic_active);
        end
        default: begin
          start = 1'b0;
          cut   = 1'b0;
        end
      endcase
    end

    fault_cut = timeout[thcut_pkg::SENS_TANK] &&
                cfg.sensor_present[thcut_pkg::SENS_TANK] &&
                (cfg.control_mode != thcut_pkg::MODE_OFF) && q_head.pwm_active;

    if (!cfg.enable) begin
      cmd_next = thcut_pkg::CMD_NONE;
    end else if (fault_cut) begin
      cmd_next = thcut_pkg::CMD_FAULT_CUT;
    end else if (cut) begin
      cmd_next = thcut_pkg::CMD_TEMP_CUT;
    end else if (start) begin
      cmd_next = thcut_pkg::CMD_START;
    end else begin
      cmd_next = thcut_pkg::CMD_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < thcut_pkg::NSENS; i++) begin
        value[i]   <= thcut_pkg::FAULT_VAL;
        last_ok[i] <= '0;
      end
      fault     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        for (int i = 0; i < thcut_pkg::NSENS; i++) begin
          value[i]   <= value_next[i];
          last_ok[i] <= last_ok_next[i];
        end
        fault     <= fault_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      command     <= cmd_next;
      tank_temp   <= value_next[thcut_pkg::SENS_TANK];
      triac_temp  <= value_next[thcut_pkg::SENS_TRIAC];
      custom_temp <= value_next[thcut_pkg::SENS_CUSTOM];
      fault_flags <= fault_next;
    end
  end

endmodule

### src/thermostat_cut_with_sensor_watchdog.sv
// The accepting edge writes the word into the queue; the back end then pops it and
// loads its result into the result register once the result side is not stalled.
// Throughput: one word per cycle while the result side is ready; the back end
// updates all sensor state per popped word, and the two-entry queue absorbs stalls on the result side.
// Reset: synchronous, active high; clears configuration, sensor state and queue.
// ---------------------------------------------------------------------------
// Thermostat cut with sensor watchdog
// Tracks three temperature sensors with an age watchdog and issues load
// start, temperature cut and fault cut commands for the tank sensor.
// ---------------------------------------------------------------------------
module thermostat_cut_with_sensor_watchdog (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [thcut_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [thcut_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [thcut_pkg::TIME_W-1:0]         now_ms,
  input  logic signed [thcut_pkg::TEMP_W-1:0]  tank_reading,
  input  logic                                 tank_valid,
  input  logic signed [thcut_pkg::TEMP_W-1:0]  triac_reading,
  input  logic                                 triac_valid,
  input  logic signed [thcut_pkg::TEMP_W-1:0]  custom_reading,
  input  logic                                 custom_valid,
  input  logic                                 manual_override,
  input  logic                                 pwm_active,
  input  logic                                 automatic_active,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           command,
  output logic signed [thcut_pkg::TEMP_W-1:0]  tank_temp,
  output logic signed [thcut_pkg::TEMP_W-1:0]  triac_temp,
  output logic signed [thcut_pkg::TEMP_W-1:0]  custom_temp,
  output logic [thcut_pkg::NSENS-1:0]          fault_flags
);

  thcut_pkg::cfg_t              cfg;
  thcut_pkg::item_t             front_item;
  thcut_pkg::item_t             q_head;
  thcut_pkg::cmd_t              back_cmd;
  logic                         q_full;
  logic                         q_nonempty;
  logic                         pop;
  logic [thcut_pkg::TEMP_W-1:0] tank_raw;
  logic [thcut_pkg::TEMP_W-1:0] triac_raw;
  logic [thcut_pkg::TEMP_W-1:0] custom_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable         <= 1'b0;
      cfg.control_mode   <= thcut_pkg::MODE_OFF;
      cfg.turn_on_level  <= '0;
      cfg.turn_off_level <= '0;
      cfg.max_error_ms   <= '0;
      cfg.sensor_present <= '0;
      cfg.manual_mode    <= 1'b0;
    end else if (cfg_write) begin
      case (thcut_pkg::reg_idx_t'(cfg_index))
        thcut_pkg::REG_ENABLE:         cfg.enable <= cfg_data[0];
        thcut_pkg::REG_CONTROL_MODE:   cfg.control_mode <= thcut_pkg::mode_t'(cfg_data[1:0]);
        thcut_pkg::REG_TURN_ON_LEVEL:  cfg.turn_on_level <= cfg_data[thcut_pkg::TEMP_W-1:0];
        thcut_pkg::REG_TURN_OFF_LEVEL: cfg.turn_off_level <= cfg_data[thcut_pkg::TEMP_W-1:0];
        thcut_pkg::REG_MAX_ERROR_MS:   cfg.max_error_ms <= cfg_data[thcut_pkg::TIME_W-1:0];
        thcut_pkg::REG_SENSOR_PRESENT: cfg.sensor_present <= cfg_data[thcut_pkg::NSENS-1:0];
        thcut_pkg::REG_MANUAL_MODE:    cfg.manual_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !q_full;

  thcut_front u_front (
    .cfg              (cfg),
    .now_ms           (now_ms),
    .tank_reading     (tank_reading),
    .tank_valid       (tank_valid),
    .triac_reading    (triac_reading),
    .triac_valid      (triac_valid),
    .custom_reading   (custom_reading),
    .custom_valid     (custom_valid),
    .manual_override  (manual_override),
    .pwm_active       (pwm_active),
    .automatic_active (automatic_active),
    .item             (front_item)
  );

  thcut_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && in_ready),
    .push_item (front_item),
    .full      (q_full),
    .pop       (pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  thcut_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_nonempty  (q_nonempty),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .command     (back_cmd),
    .tank_temp   (tank_raw),
    .triac_temp  (triac_raw),
    .custom_temp (custom_raw),
    .fault_flags (fault_flags)
  );

  assign command     = back_cmd;
  assign tank_temp   = tank_raw;
  assign triac_temp  = triac_raw;
  assign custom_temp = custom_raw;

endmodule

### src/thcut_checker.sv
// ---------------------------------------------------------------------------
// Thermostat cut checker
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "thermostat_cut_with_sensor_watchdog_defines.svh"

module thcut_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [1:0]                          command,
  input logic signed [thcut_pkg::TEMP_W-1:0] tank_temp,
  input logic [thcut_pkg::NSENS-1:0]         fault_flags
);

  // A stalled result word must not move.
  `THCUT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(command) && $stable(tank_temp) && $stable(fault_flags))

  // A fault cut is only issued while the tank watchdog has fired.
  `THCUT_ASSERT_NOW(a_fault_cut_flag, out_valid && command == thcut_pkg::CMD_FAULT_CUT, fault_flags[thcut_pkg::SENS_TANK])

  // Start and temperature cut need a healthy tank sensor.
  `THCUT_ASSERT_NOW(a_ctrl_healthy, out_valid && (command == thcut_pkg::CMD_START || command == thcut_pkg::CMD_TEMP_CUT), !fault_flags[thcut_pkg::SENS_TANK])

  // A faulted tank always reports the fault temperature.
  `THCUT_ASSERT_NOW(a_fault_value, out_valid && fault_flags[thcut_pkg::SENS_TANK], tank_temp == thcut_pkg::FAULT_VAL)

  `THCUT_ASSERT_RST(a_reset_idle, !out_valid)

endmodule

bind thermostat_cut_with_sensor_watchdog thcut_checker u_thcut_checker (.*);

### tb/thermostat_cut_with_sensor_watchdog_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Thermostat cut with sensor watchdog: testbench
// Drives control ticks through the valid/ready input, programs the registers
// between phases, and checks every result word against a cycle-free model of
// the sensor hold, the age watchdog and the load command selection.
// ---------------------------------------------------------------------------
module thermostat_cut_with_sensor_watchdog_test;
  import thcut_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASES      = 10;
  localparam int PHASE_TICKS = 120;

  typedef struct packed {
    logic [TIME_W-1:0]            now_ms;
    logic [NSENS-1:0][TEMP_W-1:0] reading;
    logic [NSENS-1:0]             good;
    logic                         manual_override;
    logic                         pwm_active;
    logic                         automatic_active;
  } tick_t;

  typedef struct packed {
    logic [1:0]                   command;
    logic [NSENS-1:0][TEMP_W-1:0] temp;
    logic [NSENS-1:0]             faults;
  } status_t;

  class thermostat_scoreboard;
    cfg_t                     cfg;
    logic signed [TEMP_W-1:0] held [NSENS];
    logic [TIME_W-1:0]        last_good [NSENS];
    logic [NSENS-1:0]         faults;
    status_t                  status_q [$];
    int                       errors;
    int                       checked;
    int                       cmd_seen [4];

    function new();
      cfg = '0;
      foreach (held[i]) begin
        held[i] = FAULT_VAL;
        last_good[i] = '0;
      end
      faults = '0;
      errors = 0;
      checked = 0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
    endfunction

    // Applies one accepted tick to the held sensor state and queues the word
    // that the block must return for it.
    function void note_input(tick_t t);
      status_t           r;
      logic [TIME_W-1:0] age;
      logic              below, above, manual_path, start, cut;
      r = '0;
      r.command = CMD_NONE;
      if (cfg.enable) begin
        for (int i = 0; i < NSENS; i++) begin
          if (cfg.sensor_present[i]) begin
            if (t.good[i]) begin
              held[i] = t.reading[i];
              last_good[i] = t.now_ms;
              faults[i] = 1'b0;
            end
            age = t.now_ms - last_good[i];
            if (age > cfg.max_error_ms) begin
              faults[i] = 1'b1;
              held[i] = FAULT_VAL;
            end
          end else begin
            held[i] = FAULT_VAL;
            faults[i] = 1'b0;
          end
        end
        start = 1'b0;
        cut = 1'b0;
        // An absent tank is never faulted, so control runs on the fault value.
        if (!faults[SENS_TANK]) begin
          below = $signed(held[SENS_TANK]) < $signed(cfg.turn_on_level);
          above = $signed(held[SENS_TANK]) >= $signed(cfg.turn_off_level);
          manual_path = cfg.manual_mode || t.manual_override;
          case (cfg.control_mode)
            MODE_AUTO: begin
              start = !cfg.manual_mode && below;
              cut = !cfg.manual_mode && above && (t.pwm_active || t.automatic_active);
            end
            MODE_MANUAL: begin
              start = manual_path && below;
              cut = manual_path && above && t.pwm_active;
            end
            MODE_BOTH: begin
              start = below;
              cut = above && (t.pwm_active || t.automatic_active);
            end
            default: ;
          endcase
        end
        if (start) r.command = CMD_START;
        if (cut) r.command = CMD_TEMP_CUT;
        age = t.now_ms - last_good[SENS_TANK];
        if (age > cfg.max_error_ms && cfg.control_mode != MODE_OFF &&
            cfg.sensor_present[SENS_TANK] && t.pwm_active)
          r.command = CMD_FAULT_CUT;
      end
      for (int i = 0; i < NSENS; i++) r.temp[i] = held[i];
      r.faults = faults;
      status_q.push_back(r);
    endfunction

    function void check_result(status_t got);
      status_t want;
      string   names [NSENS] = '{"tank_temp", "triac_temp", "custom_temp"};
      if (status_q.size() == 0) begin
        $error("result word with no tick pending: command %0d", got.command);
        errors++;
        return;
      end
      want = status_q.pop_front();
      checked++;
      cmd_seen[want.command]++;
      if (got.command !== want.command) begin
        $error("command mismatch: expected %0d, actual %0d", want.command, got.command);
        errors++;
      end
      for (int i = 0; i < NSENS; i++) begin
        if (got.temp[i] !== want.temp[i]) begin
          $error("%s mismatch: expected %0d, actual %0d", names[i],
                 $signed(want.temp[i]), $signed(got.temp[i]));
          errors++;
        end
      end
      if (got.faults !== want.faults) begin
        $error("fault_flags mismatch: expected %b, actual %b", want.faults, got.faults);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_write;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic [TIME_W-1:0]        now_ms;
  logic signed [TEMP_W-1:0] tank_reading;
  logic                     tank_valid;
  logic signed [TEMP_W-1:0] triac_reading;
  logic                     triac_valid;
  logic signed [TEMP_W-1:0] custom_reading;
  logic                     custom_valid;
  logic                     manual_override;
  logic                     pwm_active;
  logic                     automatic_active;
  logic                     out_valid;
  logic                     out_ready;
  logic [1:0]               command;
  logic signed [TEMP_W-1:0] tank_temp;
  logic signed [TEMP_W-1:0] triac_temp;
  logic signed [TEMP_W-1:0] custom_temp;
  logic [NSENS-1:0]         fault_flags;

  thermostat_scoreboard sb;
  logic [TIME_W-1:0]    clock_ms;
  logic                 in_idle_on = 1'b1;
  logic                 out_idle_on = 1'b1;
  logic                 rx_hold_request = 1'b0;
  int                   cycle_count = 0;

  thermostat_cut_with_sensor_watchdog uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .now_ms           (now_ms),
    .tank_reading     (tank_reading),
    .tank_valid       (tank_valid),
    .triac_reading    (triac_reading),
    .triac_valid      (triac_valid),
    .custom_reading   (custom_reading),
    .custom_valid     (custom_valid),
    .manual_override  (manual_override),
    .pwm_active       (pwm_active),
    .automatic_active (automatic_active),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .command          (command),
    .tank_temp        (tank_temp),
    .triac_temp       (triac_temp),
    .custom_temp      (custom_temp),
    .fault_flags      (fault_flags)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Both handshakes are sampled here; the concatenations follow the field
  // order of the packed structs, sensor 0 in the low bits.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.note_input(tick_t'({now_ms, custom_reading, triac_reading, tank_reading,
                             custom_valid, triac_valid, tank_valid,
                             manual_override, pwm_active, automatic_active}));
    if (!rst && out_valid && out_ready)
      sb.check_result(status_t'({command, custom_temp, triac_temp, tank_temp,
                                 fault_flags}));
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_request) begin
        rx_hold_request = 1'b0;
        out_ready = 1'b0;
        for (int k = 1; k < HOLD_CYCLES; k++) @(negedge clk);
      end else begin
        out_ready = !(out_idle_on && $urandom_range(99) < 7);
      end
    end
  end

  task automatic program_regs(input cfg_t c);
    reg_idx_t              idx;
    logic [CFG_DATA_W-1:0] data;
    for (int i = 0; i < idx.num(); i++) begin
      idx = reg_idx_t'(i);
      case (idx)
        REG_ENABLE:         data = CFG_DATA_W'(c.enable);
        REG_CONTROL_MODE:   data = CFG_DATA_W'(c.control_mode);
        REG_TURN_ON_LEVEL:  data = {{(CFG_DATA_W-TEMP_W){c.turn_on_level[TEMP_W-1]}},
                                    c.turn_on_level};
        REG_TURN_OFF_LEVEL: data = {{(CFG_DATA_W-TEMP_W){c.turn_off_level[TEMP_W-1]}},
                                    c.turn_off_level};
        REG_MAX_ERROR_MS:   data = c.max_error_ms;
        REG_SENSOR_PRESENT: data = CFG_DATA_W'(c.sensor_present);
        default:            data = CFG_DATA_W'(c.manual_mode);
      endcase
      cfg_write = 1'b1;
      cfg_index = idx;
      cfg_data = data;
      @(negedge clk);
    end
    cfg_write = 1'b0;
    sb.cfg = c;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_tick(input tick_t t);
    while (in_idle_on && $urandom_range(99) < 7) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    now_ms = t.now_ms;
    tank_reading = t.reading[SENS_TANK];
    triac_reading = t.reading[SENS_TRIAC];
    custom_reading = t.reading[SENS_CUSTOM];
    tank_valid = t.good[SENS_TANK];
    triac_valid = t.good[SENS_TRIAC];
    custom_valid = t.good[SENS_CUSTOM];
    manual_override = t.manual_override;
    pwm_active = t.pwm_active;
    automatic_active = t.automatic_active;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Every tick yields a word, so the block is idle once all words are back.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.status_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  function automatic tick_t mk_tick(input logic [TIME_W-1:0] now, input int t_rd,
                                    input logic t_ok, input int r_rd, input logic r_ok,
                                    input int c_rd, input logic c_ok, input logic ovr,
                                    input logic pwm, input logic aut);
    tick_t t;
    t.now_ms = now;
    t.reading = {TEMP_W'(c_rd), TEMP_W'(r_rd), TEMP_W'(t_rd)};
    t.good = {c_ok, r_ok, t_ok};
    t.manual_override = ovr;
    t.pwm_active = pwm;
    t.automatic_active = aut;
    return t;
  endfunction

  // Time mostly creeps forward on the scale of the watchdog limit, with some
  // steps right at the limit and a few arbitrary jumps.
  function automatic tick_t random_tick(input cfg_t c, input int good_pct);
    tick_t                    t;
    int                       r;
    logic [TIME_W-1:0]        lim;
    logic signed [TEMP_W-1:0] center;
    r = $urandom_range(99);
    lim = (c.max_error_ms < 400) ? c.max_error_ms / 2 + 1 : 200;
    if (r < 4) clock_ms = $urandom;
    else if (r < 14) clock_ms = clock_ms + c.max_error_ms + $urandom_range(2);
    else clock_ms = clock_ms + $urandom_range(lim);
    t.now_ms = clock_ms;
    for (int i = 0; i < NSENS; i++) begin
      if ($urandom_range(9) < 6) begin
        center = $urandom_range(1) ? c.turn_on_level : c.turn_off_level;
        t.reading[i] = TEMP_W'(int'(center) + int'($urandom_range(64)) - 32);
      end else begin
        t.reading[i] = TEMP_W'($urandom);
      end
      t.good[i] = $urandom_range(99) < good_pct;
    end
    t.manual_override = 1'($urandom_range(1));
    t.pwm_active = 1'($urandom_range(1));
    t.automatic_active = 1'($urandom_range(1));
    return t;
  endfunction

  initial begin
    cfg_t c;
    int   good_pct;
    sb = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    now_ms = '0;
    tank_reading = '0;
    tank_valid = 1'b0;
    triac_reading = '0;
    triac_valid = 1'b0;
    custom_reading = '0;
    custom_valid = 1'b0;
    manual_override = 1'b0;
    pwm_active = 1'b0;
    automatic_active = 1'b0;
    clock_ms = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed: both control paths, levels at 100 and 200, 50 ms watchdog.
    c = '0;
    c.enable = 1'b1;
    c.control_mode = MODE_BOTH;
    c.turn_on_level = 100;
    c.turn_off_level = 200;
    c.max_error_ms = 50;
    c.sensor_present = 3'b111;
    program_regs(c);
    send_tick(mk_tick(1000, 50, 1, 2047, 1, -2048, 1, 0, 1, 0));
    send_tick(mk_tick(1010, 2047, 1, -2048, 1, 2047, 1, 1, 1, 0));
    send_tick(mk_tick(1020, 200, 1, 0, 1, 0, 1, 0, 0, 1));
    send_tick(mk_tick(1030, 199, 1, 0, 0, 0, 0, 0, 1, 1));
    send_tick(mk_tick(1040, 100, 1, 0, 0, 0, 0, 0, 1, 0));
    send_tick(mk_tick(1041, 99, 1, 0, 0, 0, 0, 0, 0, 0));
    // Tank age exactly at the limit, then one past it with and without drive.
    send_tick(mk_tick(1091, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    send_tick(mk_tick(1092, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    send_tick(mk_tick(1093, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    send_tick(mk_tick(1100, 150, 1, 5, 1, -5, 1, 0, 1, 1));
    // Age measured across the 32-bit wrap of the time.
    send_tick(mk_tick(32'hFFFF_FFF0, 150, 1, 7, 1, -7, 1, 0, 1, 0));
    send_tick(mk_tick(32'h0000_0010, 150, 0, 0, 0, 0, 0, 0, 1, 0));
    send_tick(mk_tick(32'h0000_0030, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    drain();
    // Disabled: state is held and no command goes out.
    c.enable = 1'b0;
    program_regs(c);
    send_tick(mk_tick(32'h0000_0040, 300, 1, 1, 1, 1, 1, 1, 1, 1));
    send_tick(mk_tick(32'h0000_9000, -300, 1, 1, 1, 1, 1, 0, 1, 0));
    drain();
    // Tank not configured: control runs on the fault value, no fault cut.
    c.enable = 1'b1;
    c.sensor_present = 3'b110;
    program_regs(c);
    send_tick(mk_tick(32'h0001_0000, 300, 1, 11, 1, 12, 1, 0, 1, 0));
    send_tick(mk_tick(32'h0002_0000, 300, 1, 13, 0, 14, 1, 0, 1, 1));
    drain();
    // Automatic path blocked by manual mode; manual path with override only.
    c.sensor_present = 3'b111;
    c.control_mode = MODE_AUTO;
    c.manual_mode = 1'b1;
    program_regs(c);
    send_tick(mk_tick(32'h0002_0010, 0, 1, 0, 1, 0, 1, 0, 1, 1));
    drain();
    c.control_mode = MODE_MANUAL;
    c.manual_mode = 1'b0;
    program_regs(c);
    send_tick(mk_tick(32'h0002_0020, 0, 1, 0, 1, 0, 1, 1, 1, 0));
    send_tick(mk_tick(32'h0002_0030, 250, 1, 0, 1, 0, 1, 1, 1, 0));
    send_tick(mk_tick(32'h0002_0040, 250, 1, 0, 1, 0, 1, 0, 1, 1));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      c.enable = (p != 6);
      c.control_mode = (p < 8) ? mode_t'(p % 4) : mode_t'($urandom_range(3));
      if (p == 0) begin
        c.turn_on_level = TEMP_W'(TEMP_MIN);
        c.turn_off_level = TEMP_W'(-TEMP_MIN - 1);
      end else if (p == 1) begin
        c.turn_on_level = TEMP_W'(-TEMP_MIN - 1);
        c.turn_off_level = TEMP_W'(TEMP_MIN);
      end else if ($urandom_range(1)) begin
        c.turn_on_level = TEMP_W'($urandom);
        c.turn_off_level = TEMP_W'($urandom);
      end else begin
        c.turn_on_level = TEMP_W'($urandom_range(3200) - 1600);
        c.turn_off_level = c.turn_on_level + TEMP_W'($urandom_range(300));
      end
      case ($urandom_range(2))
        0:       c.max_error_ms = $urandom_range(50, 1);
        1:       c.max_error_ms = $urandom_range(2000, 100);
        default: c.max_error_ms = $urandom;
      endcase
      if (p == 2) c.max_error_ms = '0;
      if (p == 3) c.max_error_ms = '1;
      c.sensor_present = (p == 4) ? 3'b000 :
                         (p == 0 || p == 7) ? 3'b111 : 3'($urandom_range(7));
      c.manual_mode = (p < 8) ? 1'((p >> 1) & 1) : 1'($urandom_range(1));
      case ($urandom_range(2))
        0:       good_pct = 60;
        1:       good_pct = 85;
        default: good_pct = 97;
      endcase
      if (p % 3 == 0) clock_ms = 32'hFFFF_F000 + $urandom_range(12'hFFF);
      in_idle_on = (p != 5);
      out_idle_on = (p != 5);
      program_regs(c);
      if (p == 3) rx_hold_request = 1'b1;
      for (int n = 0; n < PHASE_TICKS; n++) send_tick(random_tick(c, good_pct));
      drain();
    end

    repeat (4) @(posedge clk);
    if (sb.status_q.size() != 0) begin
      $error("%0d result words never arrived", sb.status_q.size());
      sb.errors++;
    end
    $display("Covered: %0d words checked over the directed cases and %0d random settings.",
             sb.checked, PHASES);
    $display("Commands expected: %0d start, %0d temperature cut, %0d fault cut, %0d none.",
             sb.cmd_seen[CMD_START], sb.cmd_seen[CMD_TEMP_CUT], sb.cmd_seen[CMD_FAULT_CUT],
             sb.cmd_seen[CMD_NONE]);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
